FILE: rtl/core/urf_pkg.sv
// Shared types, constants and codes for the UART register file with FIFOs.
package urf_pkg;

	localparam int TX_DEPTH = 16;
	localparam int RX_DEPTH = 16;

	localparam int TX_PTR_W = $clog2(TX_DEPTH);
	localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
	localparam int RX_PTR_W = $clog2(RX_DEPTH);
	localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

	typedef logic [TX_PTR_W-1:0] tx_ptr_t;
	typedef logic [TX_CNT_W-1:0] tx_cnt_t;
	typedef logic [TX_PTR_W:0]   tx_sum_t;
	typedef logic [RX_PTR_W-1:0] rx_ptr_t;
	typedef logic [RX_CNT_W-1:0] rx_cnt_t;
	typedef logic [RX_PTR_W:0]   rx_sum_t;

	typedef enum logic [1:0] {
		FUNC_READ  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_LINE  = 2'd2,
		FUNC_TXREQ = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_DATA = 3'd0,
		REG_IER  = 3'd1,
		REG_FCR  = 3'd2,
		REG_LCR  = 3'd3,
		REG_MCR  = 3'd4,
		REG_LSR  = 3'd5
	} reg_idx_t;

	localparam int LCR_DLAB     = 7;
	localparam int FCR_FIFO_EN  = 0;
	localparam int FCR_RX_RESET = 1;
	localparam int FCR_TX_RESET = 2;
	localparam logic [7:0] FCR_STORE_MASK  = 8'hF9;
	localparam logic [7:0] IIR_NO_INT      = 8'h01;
	localparam logic [7:0] IIR_NO_INT_FIFO = 8'hC1;
	localparam int LSR_DR   = 0;
	localparam int LSR_OE   = 1;
	localparam int LSR_THRE = 5;
	localparam int LSR_TEMT = 6;

	typedef struct packed {
		logic [1:0] func;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] line_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_dropped;
	} rsp_t;

	typedef struct packed {
		logic tx_push;
		logic tx_pop;
		logic tx_flush;
		logic rx_push;
		logic rx_pop;
		logic rx_flush;
	} fifo_ctl_t;

	typedef struct packed {
		tx_cnt_t    tx_count;
		rx_cnt_t    rx_count;
		logic [7:0] tx_head;
		logic [7:0] rx_head;
	} fifo_stat_t;

endpackage

FILE: rtl/core/urf_if.sv
// Valid/ready channel interfaces for the request and response streams.
interface urf_req_if;
	logic          valid;
	logic          ready;
	urf_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface urf_rsp_if;
	logic          valid;
	logic          ready;
	urf_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/urf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module urf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/urf_fifos.sv
// Transmit and receive FIFOs: pointers, counts and head-of-queue lookahead.
module urf_fifos (
	input  logic                   clk,
	input  logic                   arst_n,
	input  urf_pkg::fifo_ctl_t     ctl,
	input  logic [7:0]             tx_wdata,
	input  logic [7:0]             rx_wdata,
	output urf_pkg::fifo_stat_t    stat
);

	urf_pkg::tx_ptr_t tx_head_q, tx_head_d, tx_head_inc, tx_tail;
	urf_pkg::tx_cnt_t tx_count_q, tx_count_d;
	urf_pkg::tx_sum_t tx_tail_sum;
	logic [7:0]       tx_ram_rd, tx_byp_data_q;
	logic             tx_byp_q;

	urf_pkg::rx_ptr_t rx_head_q, rx_head_d, rx_head_inc, rx_tail;
	urf_pkg::rx_cnt_t rx_count_q, rx_count_d;
	urf_pkg::rx_sum_t rx_tail_sum;
	logic [7:0]       rx_ram_rd, rx_byp_data_q;
	logic             rx_byp_q;

	// Transmit side
	always_comb begin
		tx_tail_sum = urf_pkg::tx_sum_t'(tx_head_q) + urf_pkg::tx_sum_t'(tx_count_q);
		if (tx_tail_sum >= urf_pkg::tx_sum_t'(urf_pkg::TX_DEPTH)) begin
			tx_tail = urf_pkg::tx_ptr_t'(tx_tail_sum - urf_pkg::tx_sum_t'(urf_pkg::TX_DEPTH));
		end else begin
			tx_tail = urf_pkg::tx_ptr_t'(tx_tail_sum);
		end
		if (tx_head_q == urf_pkg::tx_ptr_t'(urf_pkg::TX_DEPTH - 1)) begin
			tx_head_inc = '0;
		end else begin
			tx_head_inc = tx_head_q + urf_pkg::tx_ptr_t'(1);
		end
		tx_head_d  = tx_head_q;
		tx_count_d = tx_count_q;
		if (ctl.tx_flush) begin
			tx_head_d  = '0;
			tx_count_d = '0;
		end else if (ctl.tx_push) begin
			tx_count_d = tx_count_q + urf_pkg::tx_cnt_t'(1);
		end else if (ctl.tx_pop) begin
			tx_head_d  = tx_head_inc;
			tx_count_d = tx_count_q - urf_pkg::tx_cnt_t'(1);
		end
	end

	// Receive side
	always_comb begin
		rx_tail_sum = urf_pkg::rx_sum_t'(rx_head_q) + urf_pkg::rx_sum_t'(rx_count_q);
		if (rx_tail_sum >= urf_pkg::rx_sum_t'(urf_pkg::RX_DEPTH)) begin
			rx_tail = urf_pkg::rx_ptr_t'(rx_tail_sum - urf_pkg::rx_sum_t'(urf_pkg::RX_DEPTH));
		end else begin
			rx_tail = urf_pkg::rx_ptr_t'(rx_tail_sum);
		end
		if (rx_head_q == urf_pkg::rx_ptr_t'(urf_pkg::RX_DEPTH - 1)) begin
			rx_head_inc = '0;
		end else begin
			rx_head_inc = rx_head_q + urf_pkg::rx_ptr_t'(1);
		end
		rx_head_d  = rx_head_q;
		rx_count_d = rx_count_q;
		if (ctl.rx_flush) begin
			rx_head_d  = '0;
			rx_count_d = '0;
		end else if (ctl.rx_push) begin
			rx_count_d = rx_count_q + urf_pkg::rx_cnt_t'(1);
		end else if (ctl.rx_pop) begin
			rx_head_d  = rx_head_inc;
			rx_count_d = rx_count_q - urf_pkg::rx_cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q  <= '0;
			tx_count_q <= '0;
			tx_byp_q   <= 1'b0;
			rx_head_q  <= '0;
			rx_count_q <= '0;
			rx_byp_q   <= 1'b0;
		end else begin
			tx_head_q  <= tx_head_d;
			tx_count_q <= tx_count_d;
			tx_byp_q   <= ctl.tx_push && (tx_tail == tx_head_d);
			rx_head_q  <= rx_head_d;
			rx_count_q <= rx_count_d;
			rx_byp_q   <= ctl.rx_push && (rx_tail == rx_head_d);
		end
	end

	// Forward a byte written into the entry that becomes the head next cycle
	always_ff @(posedge clk) begin
		tx_byp_data_q <= tx_wdata;
		rx_byp_data_q <= rx_wdata;
	end

	// Read ahead at the next head so the head byte is ready with the next item
	urf_ram #(
		.WIDTH(8),
		.DEPTH(urf_pkg::TX_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (ctl.tx_push),
		.waddr (tx_tail),
		.wdata (tx_wdata),
		.raddr (tx_head_d),
		.rdata (tx_ram_rd)
	);

	urf_ram #(
		.WIDTH(8),
		.DEPTH(urf_pkg::RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (ctl.rx_push),
		.waddr (rx_tail),
		.wdata (rx_wdata),
		.raddr (rx_head_d),
		.rdata (rx_ram_rd)
	);

	assign stat.tx_count = tx_count_q;
	assign stat.rx_count = rx_count_q;
	assign stat.tx_head  = tx_byp_q ? tx_byp_data_q : tx_ram_rd;
	assign stat.rx_head  = rx_byp_q ? rx_byp_data_q : rx_ram_rd;

	a_tx_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.tx_push |-> tx_count_q != urf_pkg::tx_cnt_t'(urf_pkg::TX_DEPTH))
		else $error("push into full transmit FIFO");

	a_rx_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rx_push |-> rx_count_q != urf_pkg::rx_cnt_t'(urf_pkg::RX_DEPTH))
		else $error("push into full receive FIFO");

	a_tx_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.tx_pop |-> tx_count_q != '0)
		else $error("pop from empty transmit FIFO");

	a_rx_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rx_pop |-> rx_count_q != '0)
		else $error("pop from empty receive FIFO");

endmodule

FILE: rtl/core/uart_register_file_with_fifos_unit.sv
// Top level: 16550-style UART register file with transmit and receive FIFOs.
//
//   channel | role   | payload                                         | moves on
//   --------+--------+-------------------------------------------------+------------------
//   req     | sink   | func, reg_index, write_data, line_byte          | valid & ready
//   rsp     | source | read_data, tx_valid, tx_byte, rx_dropped        | valid & ready
//
// One request transfer per clock while rsp is not stalled, each giving exactly one response:
// the request lands in the stage-1 register, one pass of register decode and FIFO update
// runs against it, and the result lands in the stage-2 output register.
// The FIFO RAMs read ahead at the next head pointer, so the head byte is always ready.
// Reset (arst_n low) clears the valid flags, architectural registers, FIFO pointers and
// counts; FIFO data is undefined until written and needs no clearing pass.
// A stalled rsp holds stage 2; stage 1 then holds too and req.ready drops.
module uart_register_file_with_fifos_unit (
	input  logic     clk,
	input  logic     arst_n,
	urf_req_if.sink  req,
	urf_rsp_if.source rsp
);

	// Pipeline registers
	logic          valid_s1;
	urf_pkg::req_t item_s1;
	logic          valid_s2;
	urf_pkg::rsp_t rsp_s2;
	logic          advance_s1;

	// Architectural registers
	logic [7:0]  lcr_q;
	logic [4:0]  mcr_q;
	logic [3:0]  ier_q;
	logic [15:0] divisor_q;
	logic [7:0]  fcr_q;
	logic        overrun_q;
	logic        busy_q;

	logic [7:0]  lcr_d;
	logic [4:0]  mcr_d;
	logic [3:0]  ier_d;
	logic [15:0] divisor_d;
	logic [7:0]  fcr_d;
	logic        overrun_d;
	logic        busy_d;

	urf_pkg::fifo_ctl_t  fifo_ctl;
	urf_pkg::fifo_stat_t fifo_stat;
	urf_pkg::rsp_t       rsp_d;

	logic dlab;
	logic tx_full, tx_fifo_empty, rx_full, rx_empty;

	// Stage 1 advances whenever the output register is free or being drained
	assign advance_s1 = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready  = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req.valid || (valid_s1 && !advance_s1);
			if (advance_s1) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
		if (advance_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

	assign dlab          = lcr_q[urf_pkg::LCR_DLAB];
	assign tx_full       = fifo_stat.tx_count == urf_pkg::tx_cnt_t'(urf_pkg::TX_DEPTH);
	assign tx_fifo_empty = fifo_stat.tx_count == '0;
	assign rx_full       = fifo_stat.rx_count == urf_pkg::rx_cnt_t'(urf_pkg::RX_DEPTH);
	assign rx_empty      = fifo_stat.rx_count == '0;

	// Single-pass decode of the stage-1 item against the current register state
	always_comb begin
		lcr_d     = lcr_q;
		mcr_d     = mcr_q;
		ier_d     = ier_q;
		divisor_d = divisor_q;
		fcr_d     = fcr_q;
		overrun_d = overrun_q;
		busy_d    = busy_q;
		fifo_ctl  = '0;
		rsp_d     = '0;

		case (item_s1.func)
			urf_pkg::FUNC_READ: begin
				case (item_s1.reg_index)
					urf_pkg::REG_DATA: begin
						if (dlab) begin
							rsp_d.read_data = divisor_q[7:0];
						end else if (!rx_empty) begin
							// pop the receive head; an empty FIFO reads as zero
							rsp_d.read_data = fifo_stat.rx_head;
							fifo_ctl.rx_pop = 1'b1;
						end
					end
					urf_pkg::REG_IER: begin
						rsp_d.read_data = dlab ? divisor_q[15:8] : {4'b0000, ier_q};
					end
					urf_pkg::REG_FCR: begin
						// IIR: never an interrupt pending
						rsp_d.read_data = fcr_q[urf_pkg::FCR_FIFO_EN] ?
							urf_pkg::IIR_NO_INT_FIFO : urf_pkg::IIR_NO_INT;
					end
					urf_pkg::REG_LCR: begin
						rsp_d.read_data = lcr_q;
					end
					urf_pkg::REG_MCR: begin
						rsp_d.read_data = {3'b000, mcr_q};
					end
					urf_pkg::REG_LSR: begin
						rsp_d.read_data[urf_pkg::LSR_DR]   = !rx_empty;
						rsp_d.read_data[urf_pkg::LSR_OE]   = overrun_q;
						rsp_d.read_data[urf_pkg::LSR_THRE] = !tx_full;
						rsp_d.read_data[urf_pkg::LSR_TEMT] = tx_fifo_empty && !busy_q;
						// reading LSR clears the overrun
						overrun_d = 1'b0;
					end
					default: begin
						rsp_d.read_data = '0;
					end
				endcase
			end
			urf_pkg::FUNC_WRITE: begin
				case (item_s1.reg_index)
					urf_pkg::REG_DATA: begin
						if (dlab) begin
							divisor_d[7:0] = item_s1.write_data;
						end else if (!tx_full) begin
							// drop the byte when the transmit FIFO is full
							fifo_ctl.tx_push = 1'b1;
						end
					end
					urf_pkg::REG_IER: begin
						if (dlab) begin
							divisor_d[15:8] = item_s1.write_data;
						end else begin
							ier_d = item_s1.write_data[3:0];
						end
					end
					urf_pkg::REG_FCR: begin
						// the FIFO reset bits self-clear and are never stored
						fifo_ctl.rx_flush = item_s1.write_data[urf_pkg::FCR_RX_RESET];
						fifo_ctl.tx_flush = item_s1.write_data[urf_pkg::FCR_TX_RESET];
						fcr_d = item_s1.write_data & urf_pkg::FCR_STORE_MASK;
					end
					urf_pkg::REG_LCR: begin
						lcr_d = item_s1.write_data;
					end
					urf_pkg::REG_MCR: begin
						mcr_d = item_s1.write_data[4:0];
					end
					default: begin
						// LSR and unused offsets ignore writes
					end
				endcase
			end
			urf_pkg::FUNC_LINE: begin
				if (!rx_full) begin
					fifo_ctl.rx_push = 1'b1;
				end else begin
					overrun_d        = 1'b1;
					rsp_d.rx_dropped = 1'b1;
				end
			end
			urf_pkg::FUNC_TXREQ: begin
				if (!tx_fifo_empty) begin
					fifo_ctl.tx_pop = 1'b1;
					rsp_d.tx_valid  = 1'b1;
					rsp_d.tx_byte   = fifo_stat.tx_head;
					busy_d          = 1'b1;
				end else begin
					// nothing queued: the shifter goes idle
					busy_d = 1'b0;
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase

		// Commit nothing unless the item actually moves into the output register
		if (!advance_s1) begin
			fifo_ctl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcr_q     <= '0;
			mcr_q     <= '0;
			ier_q     <= '0;
			divisor_q <= '0;
			fcr_q     <= '0;
			overrun_q <= 1'b0;
			busy_q    <= 1'b0;
		end else if (advance_s1) begin
			lcr_q     <= lcr_d;
			mcr_q     <= mcr_d;
			ier_q     <= ier_d;
			divisor_q <= divisor_d;
			fcr_q     <= fcr_d;
			overrun_q <= overrun_d;
			busy_q    <= busy_d;
		end
	end

	urf_fifos u_fifos (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (fifo_ctl),
		.tx_wdata (item_s1.write_data),
		.rx_wdata (item_s1.line_byte),
		.stat     (fifo_stat)
	);

	a_ready_only_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && valid_s2 && !rsp.ready)
		else $error("request side stalled without a downstream stall");

	a_tx_only_on_request: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && rsp_d.tx_valid |->
			item_s1.func == urf_pkg::FUNC_TXREQ && !tx_fifo_empty)
		else $error("transmit byte produced without a request or data");

	a_drop_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && rsp_d.rx_dropped |-> rx_full && overrun_d)
		else $error("receive byte dropped while the FIFO had room");

	a_lsr_read_clears_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && item_s1.func == urf_pkg::FUNC_READ &&
			item_s1.reg_index == urf_pkg::REG_LSR |=> !overrun_q)
		else $error("overrun survived a status read");

	a_fifo_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.tx_count <= urf_pkg::tx_cnt_t'(urf_pkg::TX_DEPTH) &&
			fifo_stat.rx_count <= urf_pkg::rx_cnt_t'(urf_pkg::RX_DEPTH))
		else $error("FIFO count beyond depth");

endmodule
